// ===== design/dpcm_pkg.sv =====
// package for the looped dpcm sample decoder
// beat types for request and response, register indexes and numeric limits
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dpcm_pkg;

   localparam int unsigned ADDR_W     = 23;
   localparam int unsigned EXP_ADDR_W = 22;
   localparam int unsigned ACC_W      = 20;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam logic signed [ACC_W-1:0] ACC_MAX = 20'sh7FFFF;
   localparam logic signed [ACC_W-1:0] ACC_MIN = -20'sh80000;

   localparam logic       OP_RESTART = 1'b0;
   localparam logic       OP_STEP    = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_START_ADDR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_ADDR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_ADDR   = 2'd2;

   typedef struct packed {
      logic              op;
      logic signed [7:0] delta_byte;
      logic [7:0]        exponent_byte;
   } req_type;

   typedef struct packed {
      logic signed [ACC_W-1:0] sample_value;
      logic [ADDR_W-1:0]       next_delta_addr;
      logic [EXP_ADDR_W-1:0]   next_exponent_addr;
      logic                    loop_seen_flag;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/dpcm_sample_decoder_loop_top.sv =====
// looped dpcm sample decoder, top level
// depends on dpcm_pkg for beat types, register indexes and limits
//
// usage: the req channel carries one beat per rom step (op, delta byte and
// exponent byte fetched at the address last reported) or a restart beat.
// every accepted req beat yields exactly one rsp beat with the decoded sample,
// the next delta and exponent rom addresses and the loop seen flag.
// rsp valid rises in the cycle after req acceptance; while rsp_ready is high,
// one beat per cycle is sustained, limited by the single accumulate, saturate
// and compare path between the request port and the response register.
// the csr channel writes start, loop and end addresses; it is always ready
// and should only be used while no beat is in flight.
// reset (synchronous, active high) clears the play address, accumulator,
// loop snapshot, loop seen flag, the address registers and the response valid.
// when the receiver stalls, the response register holds its beat and req_ready
// drops until the beat is taken; a new beat is taken in the cycle it leaves.
`timescale 1ns / 1ps
`default_nettype none

module dpcm_sample_decoder_loop_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire dpcm_pkg::req_type                   req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output dpcm_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [dpcm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [dpcm_pkg::ADDR_W-1:0]         csr_wdata
);
   import dpcm_pkg::*;

   logic [ADDR_W-1:0]       start_addr_ff, loop_addr_ff, end_addr_ff;
   logic [ADDR_W-1:0]       play_addr_ff, play_addr_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] snap_ff, snap_in;
   logic                    passed_ff, passed_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   logic                    req_fire;
   logic [3:0]              nib;
   logic [3:0]              sh;
   logic [4:0]              shamt;
   logic signed [ACC_W-1:0] scaled;
   logic signed [ACC_W-1:0] addend;
   logic signed [ACC_W:0]   sum;
   logic signed [ACC_W-1:0] acc_sat;
   logic [ADDR_W:0]         next_addr;
   logic                    hit_loop;
   logic                    wrap;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_addr_ff <= '0;
         loop_addr_ff  <= '0;
         end_addr_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_START_ADDR: start_addr_ff <= csr_wdata;
            CSR_LOOP_ADDR:  loop_addr_ff  <= csr_wdata;
            CSR_END_ADDR:   end_addr_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // step datapath
   always_comb begin
      nib       = play_addr_ff[4] ? req_data.exponent_byte[7:4]
                                  : req_data.exponent_byte[3:0];
      sh        = 4'(4'd10 - nib);
      shamt     = {1'b0, sh} + 5'd1;
      scaled    = {req_data.delta_byte[7], req_data.delta_byte, 11'b0};
      addend    = scaled >>> shamt;
      sum       = {acc_ff[ACC_W-1], acc_ff} + {addend[ACC_W-1], addend};
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         acc_sat = sum[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_sat = sum[ACC_W-1:0];
      end
      next_addr = {1'b0, play_addr_ff} + {{ADDR_W{1'b0}}, 1'b1};
      hit_loop  = next_addr == {1'b0, loop_addr_ff};
      wrap      = next_addr > {1'b0, end_addr_ff};
   end

   always_comb begin
      play_addr_in = play_addr_ff;
      acc_in       = acc_ff;
      snap_in      = snap_ff;
      passed_in    = passed_ff;
      if (req_fire) begin
         if (req_data.op == OP_RESTART) begin
            play_addr_in = start_addr_ff;
            acc_in       = '0;
            snap_in      = '0;
            passed_in    = 1'b0;
         end else begin
            if (hit_loop && !passed_ff) begin
               snap_in   = acc_sat;
               passed_in = 1'b1;
            end
            if (wrap) begin
               play_addr_in = loop_addr_ff;
               acc_in       = passed_in ? snap_in : acc_sat;
            end else begin
               play_addr_in = next_addr[ADDR_W-1:0];
               acc_in       = acc_sat;
            end
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_data_in = rsp_data_ff;
      if (req_fire) begin
         rsp_data_in.sample_value       = acc_in;
         rsp_data_in.next_delta_addr    = play_addr_in;
         rsp_data_in.next_exponent_addr = {play_addr_in[21:20], 5'b0, play_addr_in[19:5]};
         rsp_data_in.loop_seen_flag     = passed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         play_addr_ff <= '0;
         acc_ff       <= '0;
         snap_ff      <= '0;
         passed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         play_addr_ff <= play_addr_in;
         acc_ff       <= acc_in;
         snap_ff      <= snap_in;
         passed_ff    <= passed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== design/dpcm_checker.sv =====
// port level checks for the looped dpcm sample decoder
// depends on dpcm_pkg; bound to dpcm_sample_decoder_loop_top
`timescale 1ns / 1ps
`default_nettype none

module dpcm_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_ready,
   input wire dpcm_pkg::req_type              req_data,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire dpcm_pkg::rsp_type              rsp_data
);
   import dpcm_pkg::*;

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   a_req_to_rsp : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted req beat gave no rsp beat");

   a_restart_clears : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.op == OP_RESTART |=>
         rsp_data.sample_value == '0 && !rsp_data.loop_seen_flag)
      else $error("restart did not clear accumulator and loop flag");

   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind dpcm_sample_decoder_loop_top dpcm_checker u_dpcm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
